// ===== hw/rtl/mask_bounding_box_tracker_macros.svh =====
// Assertion macros for the checker file of the bounding-box tracker.
`ifndef MASK_BOUNDING_BOX_TRACKER_MACROS_SVH
`define MASK_BOUNDING_BOX_TRACKER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MBBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A valid that is not taken must stay up, with its payload unchanged.
`define MBBT_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

// ===== hw/rtl/mbbt_pkg.sv =====
// Package with the shared constants and types of the bounding-box tracker.
`default_nettype none

package mbbt_pkg;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int BAND_W    = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD_BAND    = 2'd2;

  localparam logic [CFG_W-1:0]  FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [BAND_W-1:0] DEAD_BAND_RESET    = 12'd25;

  // Pixel payload.
  localparam int               PIXEL_W      = 8;
  localparam logic [PIXEL_W-1:0] OBJECT_PIXEL = 8'd255;

  // Direction codes.
  localparam int              DIR_W        = 2;
  localparam logic [DIR_W-1:0] DIR_CENTERED = 2'd0;
  localparam logic [DIR_W-1:0] DIR_BELOW    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ABOVE    = 2'd2;

  // Status of the record queue between front end and back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbbt_if.sv =====
// Valid/ready channel interfaces for the pixel input and the box result.
`default_nettype none

interface mbbt_pixel_if;
  import mbbt_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] mask_pixel;

  modport source (output valid, output mask_pixel, input ready);
  modport sink   (input valid, input mask_pixel, output ready);
endinterface

interface mbbt_box_if #(parameter int CW = 12);
  import mbbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CW-1:0]    box_left;
  logic [CW-1:0]    box_right;
  logic [CW-1:0]    box_top;
  logic [CW-1:0]    box_bottom;
  logic [CW:0]      diagonal;
  logic [DIR_W-1:0] direction;
  logic             found;

  modport source (output valid, output box_left, output box_right, output box_top,
                  output box_bottom, output diagonal, output direction, output found,
                  input ready);
  modport sink   (input valid, input box_left, input box_right, input box_top,
                  input box_bottom, input diagonal, input direction, input found,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbbt_fifo.sv =====
// Short register queue that carries finished frame records to the back end.
`default_nettype none

module mbbt_fifo import mbbt_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output q_status_t         status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      priority if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  assign pop_data     = mem[rd_ptr_r];
  assign status.full  = (count_r == NW'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/mbbt_front.sv =====
// Front end: accepts pixels, keeps the raster position and the box trackers.
`default_nettype none

module mbbt_front import mbbt_pkg::*; #(
  parameter int COORD_LIMIT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mbbt_pixel_if.sink                           in_pix,
  input  wire logic [$clog2(COORD_LIMIT)-1:0]  col_last,
  input  wire logic [$clog2(COORD_LIMIT)-1:0]  row_last,
  input  wire q_status_t                       q_status,
  output logic                                 rec_push,
  output logic [4*$clog2(COORD_LIMIT):0]       rec_data
);

  localparam int CW = $clog2(COORD_LIMIT);
  localparam logic [CW-1:0] COORD_MAX = CW'(COORD_LIMIT - 1);

  logic [CW-1:0] col_r, row_r;
  logic [CW-1:0] left_r, right_r, top_r, bottom_r;
  logic          seen_r;

  logic [CW-1:0] left_nxt, right_nxt, top_nxt, bottom_nxt;
  logic          seen_nxt;
  logic          accept, is_object, row_end, frame_end;

  assign in_pix.ready = !q_status.full;
  assign accept       = in_pix.valid && in_pix.ready;
  assign is_object    = (in_pix.mask_pixel == OBJECT_PIXEL);
  assign row_end      = (col_r >= col_last);
  assign frame_end    = row_end && (row_r >= row_last);

  always_comb begin
    left_nxt   = (is_object && col_r < left_r)   ? col_r : left_r;
    right_nxt  = (is_object && col_r > right_r)  ? col_r : right_r;
    top_nxt    = (is_object && row_r < top_r)    ? row_r : top_r;
    bottom_nxt = (is_object && row_r > bottom_r) ? row_r : bottom_r;
    seen_nxt   = seen_r || is_object;
  end

  assign rec_push = accept && frame_end;
  assign rec_data = {seen_nxt, left_nxt, right_nxt, top_nxt, bottom_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= COORD_MAX;
      right_r  <= '0;
      top_r    <= COORD_MAX;
      bottom_r <= '0;
      seen_r   <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        col_r    <= '0;
        row_r    <= '0;
        left_r   <= COORD_MAX;
        right_r  <= '0;
        top_r    <= COORD_MAX;
        bottom_r <= '0;
        seen_r   <= 1'b0;
      end else begin
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
        left_r   <= left_nxt;
        right_r  <= right_nxt;
        top_r    <= top_nxt;
        bottom_r <= bottom_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbbt_back.sv =====
// Back end: squares the box sides, takes the root bit by bit, sets direction.
`default_nettype none

module mbbt_back import mbbt_pkg::*; #(
  parameter int CW = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_status_t         q_status,
  input  wire logic [4*CW:0]     rec_data,
  output logic                   rec_pop,
  input  wire logic [CW-1:0]     centre_row,
  input  wire logic [BAND_W-1:0] band,
  mbbt_box_if.source             out_box
);

  localparam int RW    = CW + 1;
  localparam int CNT_W = $clog2(RW);
  localparam int DW    = ((CW > BAND_W) ? CW : BAND_W) + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      left_r, right_r, top_r, bottom_r;
  logic               found_r;
  logic [2*CW-1:0]    sqx_r, sqy_r;
  logic [2*RW-1:0]    rad_r;
  logic [RW+1:0]      rem_r;
  logic [RW-1:0]      root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIR_W-1:0]   dir_r;

  logic [CW-1:0]        adx, ady;
  logic signed [CW+1:0] dy_s, half_s, mid_s;
  logic signed [DW-1:0] off_s, band_s;
  logic [DIR_W-1:0]     dir_nxt;
  logic [RW+3:0]        cat, trial;

  // Side lengths as magnitudes; the squares do not care about sign.
  assign adx = (right_r >= left_r) ? right_r - left_r : left_r - right_r;
  assign ady = (bottom_r >= top_r) ? bottom_r - top_r : top_r - bottom_r;

  // Vertical midpoint, with the half of a negative height rounded toward zero.
  always_comb begin
    dy_s   = signed'({2'b00, bottom_r}) - signed'({2'b00, top_r});
    half_s = (dy_s + signed'({{(CW + 1){1'b0}}, dy_s[CW+1]})) >>> 1;
    mid_s  = signed'({2'b00, top_r}) + half_s;
    off_s  = signed'({{(DW - CW - 2){mid_s[CW+1]}}, mid_s})
           - signed'({{(DW - CW){1'b0}}, centre_row});
    band_s = signed'({{(DW - BAND_W){1'b0}}, band});
    priority if (off_s > band_s) begin
      dir_nxt = DIR_BELOW;
    end else if (off_s < -band_s) begin
      dir_nxt = DIR_ABOVE;
    end else begin
      dir_nxt = DIR_CENTERED;
    end
  end

  // One restoring square-root step: bring down two radicand bits, try 4r+1.
  assign cat   = {rem_r, rad_r[2*RW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  assign rec_pop = (state_r == S_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_status.empty) begin
            {found_r, left_r, right_r, top_r, bottom_r} <= rec_data;
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sqx_r   <= adx * adx;
          sqy_r   <= ady * ady;
          dir_r   <= dir_nxt;
          state_r <= S_SUM;
        end
        S_SUM: begin
          rad_r   <= (2*RW)'(sqx_r) + (2*RW)'(sqy_r);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (cat >= trial) begin
            rem_r  <= (RW + 2)'(cat - trial);
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= (RW + 2)'(cat);
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          rad_r <= {rad_r[2*RW-3:0], 2'b00};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(RW - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_box.ready) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_box.valid      = (state_r == S_OUT);
  assign out_box.box_left   = left_r;
  assign out_box.box_right  = right_r;
  assign out_box.box_top    = top_r;
  assign out_box.box_bottom = bottom_r;
  assign out_box.diagonal   = root_r;
  assign out_box.direction  = dir_r;
  assign out_box.found      = found_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mask_bounding_box_tracker.sv =====
// Top level of the binary mask bounding-box tracker.
//
//   Channel   Direction  Payload                                Handshake
//   in_pix    in         mask_pixel                             valid / ready
//   out_box   out        box_left/right/top/bottom, diagonal,   valid / ready
//                        direction, found
//   cfg_*     in         cfg_index, cfg_wdata                   cfg_we, no wait
//
// The front end takes one pixel transaction per cycle while the record queue has room.
// The back end works on one frame result at a time (load, square, sum, the root over
// CW+1 bits one bit at a time, output); the bit-serial square root sets its pace, and
// frames shorter than the back-end pass fill the queue and stall input.
// A result waits in the output registers until taken; the front end keeps counting
// pixels into the queue meanwhile.
// Reset is synchronous and active low; it loads the register defaults and clears the
// counters and trackers directly, with no clearing pass.
`default_nettype none

module mask_bounding_box_tracker import mbbt_pkg::*; #(
  parameter int COORD_LIMIT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  mbbt_pixel_if.sink                in_pix,
  mbbt_box_if.source                out_box,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Coordinates run from 0 to COORD_LIMIT-1.
  localparam int CW = $clog2(COORD_LIMIT);
  // Width in which a written size is compared against the coordinate limit.
  localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int REC_W = 4 * CW + 1;
  localparam int QUEUE_DEPTH = 2;

  logic [CFG_W-1:0]  frame_width_r, frame_height_r;
  logic [BAND_W-1:0] dead_band_r;

  logic [SW-1:0]  w_ext, h_ext, w_eff, h_eff;
  logic [CW-1:0]  col_last, row_last, centre_row;

  logic             rec_push, rec_pop;
  logic [REC_W-1:0] rec_in, rec_out;
  q_status_t        q_status;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
      dead_band_r    <= DEAD_BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_IDX_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_IDX_DEAD_BAND:    dead_band_r    <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one, and a size beyond the coordinate range is clamped.
  always_comb begin
    w_ext = SW'(frame_width_r);
    h_ext = SW'(frame_height_r);
    priority if (w_ext == '0) begin
      w_eff = SW'(1);
    end else if (w_ext > SW'(COORD_LIMIT)) begin
      w_eff = SW'(COORD_LIMIT);
    end else begin
      w_eff = w_ext;
    end
    priority if (h_ext == '0) begin
      h_eff = SW'(1);
    end else if (h_ext > SW'(COORD_LIMIT)) begin
      h_eff = SW'(COORD_LIMIT);
    end else begin
      h_eff = h_ext;
    end
  end

  // Last column and row index of a frame, and the center row used for direction.
  assign col_last   = CW'(w_eff - SW'(1));
  assign row_last   = CW'(h_eff - SW'(1));
  assign centre_row = CW'(h_eff >> 1);

  // The front end tracks the box and pushes one record at the last pixel of a frame.
  mbbt_front #(
    .COORD_LIMIT (COORD_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .col_last (col_last),
    .row_last (row_last),
    .q_status (q_status),
    .rec_push (rec_push),
    .rec_data (rec_in)
  );

  // The queue decouples pixel intake from the slower per-frame arithmetic.
  mbbt_fifo #(
    .W     (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_in),
    .pop       (rec_pop),
    .pop_data  (rec_out),
    .status    (q_status)
  );

  // The back end turns each record into one result transaction.
  mbbt_back #(
    .CW (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .rec_data   (rec_out),
    .rec_pop    (rec_pop),
    .centre_row (centre_row),
    .band       (dead_band_r),
    .out_box    (out_box)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mbbt_checker.sv =====
// Port-level checker for the bounding-box tracker, bound to the top level.
`default_nettype none

`include "mask_bounding_box_tracker_macros.svh"

module mbbt_checker #(
  parameter int COORD_LIMIT = 4096
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [$clog2(COORD_LIMIT)-1:0] box_left,
  input wire logic [$clog2(COORD_LIMIT)-1:0] box_right,
  input wire logic [$clog2(COORD_LIMIT)-1:0] box_top,
  input wire logic [$clog2(COORD_LIMIT)-1:0] box_bottom,
  input wire logic [$clog2(COORD_LIMIT):0]   diagonal,
  input wire logic [1:0]                     direction,
  input wire logic                           found
);

  localparam int CW = $clog2(COORD_LIMIT);
  localparam logic [CW-1:0] COORD_MAX = CW'(COORD_LIMIT - 1);

  // A pending result stays offered and unchanged until it is taken.
  `MBBT_ASSERT_HOLD(a_out_hold, out_valid, out_ready,
    {box_left, box_right, box_top, box_bottom, diagonal, direction, found},
    "result changed or dropped while stalled")

  // An empty frame reports the cleared trackers.
  `MBBT_ASSERT(a_empty_box, (out_valid && !found) |-> (box_left == COORD_MAX && box_right == '0 && box_top == COORD_MAX && box_bottom == '0), "empty frame with a non-cleared box")

  // A frame with an object reports an ordered box.
  `MBBT_ASSERT(a_box_order, (out_valid && found) |-> (box_left <= box_right && box_top <= box_bottom), "box corners out of order")

  // The diagonal is never shorter than the box width.
  `MBBT_ASSERT(a_diag_width, (out_valid && found) |-> ((CW + 1)'(box_right - box_left) <= diagonal), "diagonal shorter than box width")

endmodule

bind mask_bounding_box_tracker mbbt_checker #(
  .COORD_LIMIT (COORD_LIMIT)
) u_mbbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_box.valid),
  .out_ready  (out_box.ready),
  .box_left   (out_box.box_left),
  .box_right  (out_box.box_right),
  .box_top    (out_box.box_top),
  .box_bottom (out_box.box_bottom),
  .diagonal   (out_box.diagonal),
  .direction  (out_box.direction),
  .found      (out_box.found)
);

`default_nettype wire
